[design/krt_pkg.sv]
// Package for the keyed record table: table depth, derived widths, word types,
// command and status codes, controller states and the cell control bundle.
// Used by every module of the block; depends on nothing.
package krt_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int CMD_W  = 2;
	localparam int KEY_W  = 54;
	localparam int PAY_W  = 64;
	localparam int STAT_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_DUMP   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	// Input word
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [KEY_W-1:0]  found_key;
		logic [PAY_W-1:0]  found_payload;
		logic              last;
	} out_word_t;

	// What one cell does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_SHIFT = 2'd1,
		CELL_LOAD  = 2'd2
	} cell_op_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_SCAN   = 3'd1,
		S_FINISH = 3'd2,
		S_DUMP   = 3'd3,
		S_ROTATE = 3'd4
	} state_t;

	// Control bundle from the controller to the cell row
	typedef struct packed {
		logic             rotate;    // whole ring moves one place toward cell 0
		logic             compact;   // cells at and above pos take from their neighbor
		logic [IDX_W-1:0] pos;
		logic             load;      // one cell takes the broadcast entry
		logic [IDX_W-1:0] load_idx;
	} cell_ctl_t;

endpackage

[design/krt_cell.sv]
// One table cell: holds a key and a payload, and either keeps them, takes its
// neighbor's entry, or takes a new entry. Depends on krt_pkg.
module krt_cell
	import krt_pkg::*;
(
	input  logic             clk,
	input  cell_op_t         op,
	input  logic [KEY_W-1:0] nxt_key,
	input  logic [PAY_W-1:0] nxt_pay,
	input  logic [KEY_W-1:0] ld_key,
	input  logic [PAY_W-1:0] ld_pay,
	output logic [KEY_W-1:0] key,
	output logic [PAY_W-1:0] pay
);

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;

	// Entry storage, no reset: never read before written
	always_ff @(posedge clk) begin
		unique case (op)
			CELL_SHIFT: begin
				key_q <= nxt_key;
				pay_q <= nxt_pay;
			end
			CELL_LOAD: begin
				key_q <= ld_key;
				pay_q <= ld_pay;
			end
			default: begin
				key_q <= key_q;
				pay_q <= pay_q;
			end
		endcase
	end

	assign key = key_q;
	assign pay = pay_q;

endmodule

[design/krt_ctrl.sv]
// Controller of the keyed record table: command sequencing, entry count,
// head-of-ring compare and the output word register. Depends on krt_pkg.
module krt_ctrl
	import krt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_word,
	input  logic [KEY_W-1:0] head_key,
	input  logic [PAY_W-1:0] head_pay,
	output cell_ctl_t        ctl,
	output logic [KEY_W-1:0] ld_key,
	output logic [PAY_W-1:0] ld_pay
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             found_q, found_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	logic [PAY_W-1:0] fpay_q, fpay_d;
	cmd_t             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic             out_valid_q;
	out_word_t        out_word_q;

	logic             slot_free;
	logic             emit;
	out_word_t        emit_word;
	logic             idx_last;
	logic             idx_in_use;
	logic             scan_hit;
	logic             dump_last;
	logic             take_in;
	logic             tbl_empty;
	logic             tbl_full;

	assign in_ready   = (state_q == S_IDLE);
	assign take_in    = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign idx_last   = (idx_q == IDX_W'(TABLE_DEPTH - 1));
	assign idx_in_use = (CNT_W'(idx_q) < cnt_q);
	assign scan_hit   = (head_key == key_q) && idx_in_use && !found_q;
	assign dump_last  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign tbl_empty  = (cnt_q == '0);
	assign tbl_full   = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign ld_key     = key_q;
	assign ld_pay     = pay_q;

	// Next state, ring control and result word
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		found_d   = found_q;
		pos_d     = pos_q;
		fpay_d    = fpay_q;
		emit      = 1'b0;
		emit_word = '0;
		ctl       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					idx_d   = '0;
					found_d = 1'b0;
					if (cmd_t'(in_word.command) == CMD_DUMP) begin
						state_d = tbl_empty ? S_FINISH : S_DUMP;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			// one full turn of the ring, head entry compared each cycle
			S_SCAN: begin
				ctl.rotate = 1'b1;
				if (scan_hit) begin
					found_d = 1'b1;
					pos_d   = idx_q;
					fpay_d  = head_pay;
				end
				idx_d = idx_q + IDX_W'(1);
				if (idx_last) begin
					state_d = S_FINISH;
				end
			end
			// single result, plus the insert or the compaction
			S_FINISH: begin
				if (slot_free) begin
					emit           = 1'b1;
					emit_word.last = 1'b1;
					state_d        = S_IDLE;
					unique case (cmd_q)
						CMD_INSERT: begin
							if (found_q) begin
								emit_word.status = ST_DUPLICATE;
							end else if (tbl_full) begin
								emit_word.status = ST_FULL;
							end else begin
								emit_word.status = ST_OK;
								ctl.load         = 1'b1;
								ctl.load_idx     = cnt_q[IDX_W-1:0];
								cnt_d            = cnt_q + CNT_W'(1);
							end
						end
						CMD_SEARCH: begin
							if (tbl_empty) begin
								emit_word.status = ST_EMPTY;
							end else if (found_q) begin
								emit_word.status        = ST_OK;
								emit_word.found_key     = key_q;
								emit_word.found_payload = fpay_q;
							end else begin
								emit_word.status = ST_NOT_FOUND;
							end
						end
						CMD_DELETE: begin
							if (tbl_empty) begin
								emit_word.status = ST_EMPTY;
							end else if (found_q) begin
								emit_word.status = ST_OK;
								ctl.compact      = 1'b1;
								ctl.pos          = pos_q;
								cnt_d            = cnt_q - CNT_W'(1);
							end else begin
								emit_word.status = ST_NOT_FOUND;
							end
						end
						default: begin
							emit_word.status = ST_EMPTY;
						end
					endcase
				end
			end
			// one result per stored entry, ring turns as each is taken
			S_DUMP: begin
				if (slot_free) begin
					emit                    = 1'b1;
					emit_word.status        = ST_OK;
					emit_word.found_key     = head_key;
					emit_word.found_payload = head_pay;
					emit_word.last          = dump_last;
					ctl.rotate              = 1'b1;
					idx_d                   = idx_q + IDX_W'(1);
					if (dump_last) begin
						state_d = idx_last ? S_IDLE : S_ROTATE;
					end
				end
			end
			// finish the turn so entries return to their places
			S_ROTATE: begin
				ctl.rotate = 1'b1;
				idx_d      = idx_q + IDX_W'(1);
				if (idx_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			found_q <= found_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		fpay_q <= fpay_d;
		if (take_in) begin
			cmd_q <= cmd_t'(in_word.command);
			key_q <= in_word.key;
			pay_q <= in_word.payload;
		end
		if (emit) begin
			out_word_q <= emit_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

[design/keyed_record_table_top.sv]
// Top level of the keyed record table: a ring of entry cells and its controller.
// Depends on krt_pkg, krt_cell and krt_ctrl.

// The table is a ring of TABLE_DEPTH cells, each holding one entry; the ring
// turns one place per cycle, in a dump only as the output takes each word, and
// the controller looks only at the entry in cell 0. Insert, search and delete
// each take one full turn to check every stored key, then place the result
// word (and write the new entry or close the gap left by a deleted one). A
// dump turns the ring once as well, giving one result word per stored entry
// as the output takes them. A new input word is taken once the previous one
// is done, while its last result may still wait in the output register.
module keyed_record_table_top
	import krt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	cell_ctl_t        ctl;
	logic [KEY_W-1:0] ld_key;
	logic [PAY_W-1:0] ld_pay;
	logic [KEY_W-1:0] key_a [TABLE_DEPTH];
	logic [PAY_W-1:0] pay_a [TABLE_DEPTH];
	cell_op_t         op_a  [TABLE_DEPTH];

	krt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.head_key  (key_a[0]),
		.head_pay  (pay_a[0]),
		.ctl       (ctl),
		.ld_key    (ld_key),
		.ld_pay    (ld_pay)
	);

	// Cell ring: each cell takes from the next one, the last from cell 0
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		localparam int NXT = (i + 1) % TABLE_DEPTH;

		// per-cell operation from the shared control bundle
		always_comb begin
			if (ctl.load && (ctl.load_idx == IDX_W'(i))) begin
				op_a[i] = CELL_LOAD;
			end else if (ctl.rotate || (ctl.compact && (IDX_W'(i) >= ctl.pos))) begin
				op_a[i] = CELL_SHIFT;
			end else begin
				op_a[i] = CELL_HOLD;
			end
		end

		krt_cell u_cell (
			.clk     (clk),
			.op      (op_a[i]),
			.nxt_key (key_a[NXT]),
			.nxt_pay (pay_a[NXT]),
			.ld_key  (ld_key),
			.ld_pay  (ld_pay),
			.key     (key_a[i]),
			.pay     (pay_a[i])
		);
	end

endmodule

[tb/sv/keyed_record_table_top_tb.sv]
// Self-checking testbench for keyed_record_table_top: random and directed insert, search,
// delete and dump words, checked against an in-bench model of the record table.
// Depends on krt_pkg and the keyed_record_table_top RTL.
module keyed_record_table_top_tb;
	import krt_pkg::*;

	localparam int HOLD_CYCLES  = 400;             // long output hold-off during the fill
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8; // one scan plus result placement, with margin
	// Longest correct gap: the hold-off, a full scan and a sender gap; taken several times over.
	localparam int STALL_LIMIT  = 4000;

	localparam logic [KEY_W-1:0] KEY_ONES      = '1;
	localparam logic [KEY_W-1:0] KEY_16_DIGITS = 54'd9999999999999999;
	localparam logic [KEY_W-1:0] KEY_ABSENT    = 54'd12345;

	// Model of the table plus the queue of result words still owed by the block
	class table_scoreboard;
		logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
		logic [PAY_W-1:0] pay_mem [TABLE_DEPTH];
		int unsigned      n_entries;
		out_word_t        owed_q [$];
		int unsigned      n_errors;
		int unsigned      n_results;

		function new();
			n_entries = 0;
			n_errors  = 0;
			n_results = 0;
		endfunction

		// first filled slot holding k, or -1
		function int find_slot(logic [KEY_W-1:0] k);
			for (int i = 0; i < n_entries; i++) begin
				if (key_mem[i] == k)
					return i;
			end
			return -1;
		endfunction

		function void owe(status_t st, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p, logic lst);
			out_word_t r;
			r.status        = st;
			r.found_key     = k;
			r.found_payload = p;
			r.last          = lst;
			owed_q.push_back(r);
		endfunction

		// Apply one accepted input word and queue the result words it causes
		function void note_input(in_word_t w);
			int slot;
			slot = find_slot(w.key);
			case (w.command)
				CMD_INSERT: begin
					if (slot >= 0) begin
						owe(ST_DUPLICATE, '0, '0, 1'b1);
					end else if (n_entries >= TABLE_DEPTH) begin
						owe(ST_FULL, '0, '0, 1'b1);
					end else begin
						key_mem[n_entries] = w.key;
						pay_mem[n_entries] = w.payload;
						n_entries++;
						owe(ST_OK, '0, '0, 1'b1);
					end
				end
				CMD_SEARCH: begin
					if (n_entries == 0)
						owe(ST_EMPTY, '0, '0, 1'b1);
					else if (slot < 0)
						owe(ST_NOT_FOUND, '0, '0, 1'b1);
					else
						owe(ST_OK, key_mem[slot], pay_mem[slot], 1'b1);
				end
				CMD_DELETE: begin
					if (n_entries == 0) begin
						owe(ST_EMPTY, '0, '0, 1'b1);
					end else if (slot < 0) begin
						owe(ST_NOT_FOUND, '0, '0, 1'b1);
					end else begin
						// close the gap: later entries move down one place
						for (int i = slot; i + 1 < n_entries; i++) begin
							key_mem[i] = key_mem[i + 1];
							pay_mem[i] = pay_mem[i + 1];
						end
						n_entries--;
						owe(ST_OK, '0, '0, 1'b1);
					end
				end
				default: begin
					if (n_entries == 0) begin
						owe(ST_EMPTY, '0, '0, 1'b1);
					end else begin
						for (int i = 0; i < n_entries; i++)
							owe(ST_OK, key_mem[i], pay_mem[i], i + 1 == n_entries);
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			n_errors++;
			if (n_errors <= 40)
				$display("mismatch at result %0d: %s", n_results, msg);
		endtask

		// Compare one accepted result word with the oldest owed one
		task check_result(out_word_t got);
			out_word_t want;
			n_results++;
			if (owed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", got));
			end else begin
				want = owed_q.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
				if (got.found_key !== want.found_key)
					report_mismatch($sformatf("found_key %h, want %h",
						got.found_key, want.found_key));
				if (got.found_payload !== want.found_payload)
					report_mismatch($sformatf("found_payload %h, want %h",
						got.found_payload, want.found_payload));
				if (got.last !== want.last)
					report_mismatch($sformatf("last %b, want %b", got.last, want.last));
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	bit calm;     // no idling on either side
	bit hold_req; // asks the result side for a long hold-off

	table_scoreboard sb = new();

	keyed_record_table_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [KEY_W-1:0] rand_key();
		logic [63:0] r;
		r = {$urandom, $urandom};
		// a small key pool now and then, so that repeats happen
		if ($urandom_range(0, 3) == 0)
			r = 64'($urandom_range(0, 15));
		return r[KEY_W-1:0];
	endfunction

	function automatic logic [PAY_W-1:0] rand_payload();
		return {$urandom, $urandom};
	endfunction

	// a key currently stored in the table, when there is one
	function automatic logic [KEY_W-1:0] live_key();
		if (sb.n_entries == 0)
			return rand_key();
		return sb.key_mem[$urandom_range(0, sb.n_entries - 1)];
	endfunction

	function automatic in_word_t word_of(cmd_t c, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		in_word_t w;
		w.command = c;
		w.key     = k;
		w.payload = p;
		return w;
	endfunction

	// Offer one input word, maybe after an idle burst, and hold it until taken
	task automatic offer(input in_word_t w);
		int gap;
		if (!calm && $urandom_range(0, 99) < 25) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_word  = w;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
	endtask

	// Random words; weights in percent, the remainder goes to dumps
	task automatic random_mix(input int n, input int ins_w, input int srch_w, input int del_w);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < ins_w)
				offer(word_of(CMD_INSERT,
					($urandom_range(0, 99) < 15) ? live_key() : rand_key(), rand_payload()));
			else if (r < ins_w + srch_w)
				offer(word_of(CMD_SEARCH,
					($urandom_range(0, 99) < 70) ? live_key() : rand_key(), rand_payload()));
			else if (r < ins_w + srch_w + del_w)
				offer(word_of(CMD_DELETE,
					($urandom_range(0, 99) < 70) ? live_key() : rand_key(), rand_payload()));
			else
				offer(word_of(CMD_DUMP, rand_key(), rand_payload()));
		end
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < 10) begin
				stall_left = $urandom_range(1, 11) - 1;
				out_ready  = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_word);
		end
	end

	// Ends the run when no word moves on either side for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_word  = '0;
		calm     = 1'b0;
		hold_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, extreme keys and payloads, duplicates, shifts
		offer(word_of(CMD_SEARCH, '0, '1));
		offer(word_of(CMD_DELETE, KEY_ONES, '0));
		offer(word_of(CMD_DUMP, '0, '0));
		offer(word_of(CMD_INSERT, '0, '0));
		offer(word_of(CMD_INSERT, KEY_ONES, '1));
		offer(word_of(CMD_INSERT, KEY_16_DIGITS, rand_payload()));
		offer(word_of(CMD_INSERT, '0, '1));
		offer(word_of(CMD_INSERT, KEY_ONES, '0));
		offer(word_of(CMD_SEARCH, '0, '0));
		offer(word_of(CMD_SEARCH, KEY_ONES, '0));
		offer(word_of(CMD_SEARCH, KEY_16_DIGITS, '0));
		offer(word_of(CMD_SEARCH, KEY_ABSENT, '1));
		offer(word_of(CMD_DELETE, KEY_ABSENT, '0));
		offer(word_of(CMD_DELETE, KEY_ONES, '0));      // middle entry, later one moves down
		offer(word_of(CMD_SEARCH, KEY_16_DIGITS, '0));
		offer(word_of(CMD_DUMP, rand_key(), rand_payload()));
		offer(word_of(CMD_DELETE, '0, '0));            // first entry
		offer(word_of(CMD_DELETE, KEY_16_DIGITS, '0)); // last entry, table empty again
		offer(word_of(CMD_DUMP, '0, '0));
		offer(word_of(CMD_SEARCH, KEY_16_DIGITS, '0));
		offer(word_of(CMD_INSERT, {27{2'b10}}, {32{2'b01}}));
		offer(word_of(CMD_INSERT, {27{2'b01}}, {32{2'b10}}));
		offer(word_of(CMD_DUMP, '0, '1));
		wait_drained();

		// Random mix around a small table
		random_mix(10, 45, 25, 20);

		// Fill to the top while the result side holds off, then work a full table
		hold_req = 1'b1;
		while (sb.n_entries < TABLE_DEPTH)
			offer(word_of(CMD_INSERT,
				($urandom_range(0, 9) == 0) ? live_key() : rand_key(), rand_payload()));
		offer(word_of(CMD_INSERT, rand_key() | 54'h1_0000, rand_payload()));
		offer(word_of(CMD_INSERT, live_key(), rand_payload())); // duplicate wins over full
		offer(word_of(CMD_SEARCH, sb.key_mem[TABLE_DEPTH-1], rand_payload()));
		offer(word_of(CMD_SEARCH, sb.key_mem[0], rand_payload()));
		offer(word_of(CMD_DUMP, rand_key(), rand_payload()));
		offer(word_of(CMD_DELETE, sb.key_mem[0], rand_payload()));
		offer(word_of(CMD_DELETE, sb.key_mem[sb.n_entries-1], rand_payload()));
		offer(word_of(CMD_INSERT, rand_key() | 54'h2_0000, rand_payload()));
		wait_drained();

		// Delete-heavy mix, last stretch without idling
		random_mix(10, 20, 20, 50);
		calm = 1'b1;
		random_mix(8, 35, 25, 30);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.n_errors == 0 && sb.owed_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
design/krt_pkg.sv
design/krt_cell.sv
design/krt_ctrl.sv
design/keyed_record_table_top.sv
tb/sv/keyed_record_table_top_tb.sv
